// File: src/tbfe_pkg.sv
// Shared constants, types and microcode program of the three-band FIR equalizer.
`timescale 1ns / 1ps

package tbfe_pkg;

   localparam int TAPS    = 320;
   localparam int TAP_W   = $clog2(TAPS);
   localparam int CNT_W   = $clog2(TAPS + 1);
   // Only bits 30..15 of the total reach the output, so sums wrap at 31 bits.
   localparam int ACC_W   = 31;
   localparam int SHIFT_Q = 15;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   localparam logic [1:0] BAND_LOW  = 2'd0;
   localparam logic [1:0] BAND_MID  = 2'd1;
   localparam logic [1:0] BAND_HIGH = 2'd2;

   localparam logic [1:0] REG_GAIN_LOW  = 2'd0;
   localparam logic [1:0] REG_GAIN_MID  = 2'd1;
   localparam logic [1:0] REG_GAIN_HIGH = 2'd2;

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_MAC    = 3'd1;
   localparam step_type STEP_DRAIN1 = 3'd2;
   localparam step_type STEP_DRAIN2 = 3'd3;
   localparam step_type STEP_GAIN   = 3'd4;
   localparam step_type STEP_OUT    = 3'd5;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_START,
      COND_TAP_LAST,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     issue;      // read one tap from all memories
      logic     load_gain;  // scale the three band sums by their gains
      logic     load_out;   // load the sum of the scaled sums into the output register
      cond_type cond;
      step_type jump_step;  // taken when cond holds
      step_type next_step;  // taken otherwise
   } ctl_word_type;

   function automatic ctl_word_type ucode_rom(input step_type step);
      ctl_word_type w;
      w = '{issue: 1'b0, load_gain: 1'b0, load_out: 1'b0, cond: COND_ALWAYS,
            jump_step: STEP_IDLE, next_step: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.cond      = COND_START;
            w.jump_step = STEP_MAC;
            w.next_step = STEP_IDLE;
         end
         STEP_MAC: begin
            w.issue     = 1'b1;
            w.cond      = COND_TAP_LAST;
            w.jump_step = STEP_DRAIN1;
            w.next_step = STEP_MAC;
         end
         STEP_DRAIN1: begin
            w.jump_step = STEP_DRAIN2;
         end
         STEP_DRAIN2: begin
            w.jump_step = STEP_GAIN;
         end
         STEP_GAIN: begin
            w.load_gain = 1'b1;
            w.jump_step = STEP_OUT;
         end
         STEP_OUT: begin
            w.load_out  = 1'b1;
            w.cond      = COND_OUT_BUSY;
            w.jump_step = STEP_OUT;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.jump_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: src/three_band_fir_equalizer_unit.sv
// Three-band FIR equalizer: microcoded sequencer, memories and MAC datapath.
//
// Usage. Items arrive on the req_ channel (valid/stall): a beat with
// req_kind = 0 filters req_sample_in and yields one beat on the rsp_
// channel; a beat with req_kind = 1 stores req_coef_value in the band and
// tap given by req_coef_band and req_coef_index and yields nothing.
// Gains are written on the csr_ channel (valid/ready, always ready): index
// 0 low, 1 mid, 2 high; other indexes are dropped. The user must write
// them only while the block is idle; the block itself does not enforce it.
// A sample goes from its beat to its result through a multiply-accumulate
// pass of one tap per cycle (all three bands share one read port per
// memory), two pipeline drain steps, one gain step and one sum step.
// req_stall stays high during that pass, so one sample is in flight at a
// time. The result waits in an output register; when rsp_stall holds it,
// the next sample may still be taken and filtered, and its pass waits at
// the final step until the register is free. Reset clears the sequencer,
// sets the gains to 0, 1, 0 and empties the delay line at once through a
// fill count; coefficient memories are not cleared and must be written
// before use.
`timescale 1ns / 1ps

module three_band_fir_equalizer_unit
   import tbfe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [15:0] req_sample_in,
   input  logic        [1:0]  req_coef_band,
   input  logic        [8:0]  req_coef_index,
   input  logic signed [15:0] req_coef_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [15:0] csr_data
);

   localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

   logic [15:0] delay_mem [TAPS];
   logic [15:0] coef_low_mem [TAPS];
   logic [15:0] coef_mid_mem [TAPS];
   logic [15:0] coef_high_mem [TAPS];

   step_type     step_ff, step_in;
   ctl_word_type ctl;
   logic         cond_true;

   logic req_accept, sample_start, coef_write, out_busy, out_load;

   logic [15:0] gain_low_ff, gain_mid_ff, gain_high_ff;

   logic [TAP_W-1:0] wr_ptr_ff, rd_ptr_ff, tap_ff;
   logic [CNT_W-1:0] fill_ff;

   logic signed [15:0]      d_rd_ff, cl_rd_ff, cm_rd_ff, ch_rd_ff;
   logic                    zero_ff, rd_vld_ff, mul_vld_ff;
   logic signed [15:0]      d_use;
   logic signed [ACC_W-1:0] p_low, p_mid, p_high;
   logic [ACC_W-1:0]   prod_low_ff, prod_mid_ff, prod_high_ff;
   logic [ACC_W-1:0]   acc_low_ff, acc_mid_ff, acc_high_ff;
   logic [ACC_W-1:0]   scl_low_ff, scl_mid_ff, scl_high_ff;
   logic [ACC_W-1:0]   total;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_data_ff;

   // Handshakes.
   assign req_stall    = (step_ff != STEP_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign sample_start = req_accept && (req_kind == KIND_SAMPLE);
   assign coef_write   = req_accept && (req_kind == KIND_COEF)
                         && (32'(req_coef_index) < 32'(TAPS));
   assign out_busy     = rsp_valid_ff && rsp_stall;
   assign csr_ready    = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // Sequencer: fetch the control word and pick the next step.
   always_comb begin
      ctl = ucode_rom(step_ff);
      case (ctl.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_START:    cond_true = sample_start;
         COND_TAP_LAST: cond_true = (tap_ff == LAST_TAP);
         COND_OUT_BUSY: cond_true = out_busy;
         default:       cond_true = 1'b1;
      endcase
      step_in  = cond_true ? ctl.jump_step : ctl.next_step;
      out_load = ctl.load_out && !out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Gain registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_low_ff  <= 16'd0;
         gain_mid_ff  <= 16'd1;
         gain_high_ff <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GAIN_LOW:  gain_low_ff  <= csr_data;
            REG_GAIN_MID:  gain_mid_ff  <= csr_data;
            REG_GAIN_HIGH: gain_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Coefficient memories.
   always_ff @(posedge clock) begin
      if (coef_write) begin
         case (req_coef_band)
            BAND_LOW:  coef_low_mem[TAP_W'(req_coef_index)]  <= req_coef_value;
            BAND_MID:  coef_mid_mem[TAP_W'(req_coef_index)]  <= req_coef_value;
            BAND_HIGH: coef_high_mem[TAP_W'(req_coef_index)] <= req_coef_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         cl_rd_ff <= coef_low_mem[tap_ff];
         cm_rd_ff <= coef_mid_mem[tap_ff];
         ch_rd_ff <= coef_high_mem[tap_ff];
      end
   end

   // Delay line as a circular buffer. Tap n reads the sample written n
   // beats ago; taps at or beyond the fill count read as zero.
   always_ff @(posedge clock) begin
      if (sample_start) begin
         delay_mem[wr_ptr_ff] <= req_sample_in;
      end
      if (ctl.issue) begin
         d_rd_ff <= delay_mem[rd_ptr_ff];
         zero_ff <= (CNT_W'(tap_ff) >= fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else if (sample_start) begin
         wr_ptr_ff <= (wr_ptr_ff == LAST_TAP) ? '0 : wr_ptr_ff + 1'b1;
         if (fill_ff < CNT_W'(TAPS)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sample_start) begin
         rd_ptr_ff <= wr_ptr_ff;
         tap_ff    <= '0;
      end else if (ctl.issue) begin
         rd_ptr_ff <= (rd_ptr_ff == '0) ? LAST_TAP : rd_ptr_ff - 1'b1;
         tap_ff    <= tap_ff + 1'b1;
      end
   end

   // Multiply-accumulate pipeline: read, multiply, accumulate.
   assign d_use  = zero_ff ? 16'sd0 : d_rd_ff;
   assign p_low  = ACC_W'(cl_rd_ff) * ACC_W'(d_use);
   assign p_mid  = ACC_W'(cm_rd_ff) * ACC_W'(d_use);
   assign p_high = ACC_W'(ch_rd_ff) * ACC_W'(d_use);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= ctl.issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_low_ff  <= p_low;
      prod_mid_ff  <= p_mid;
      prod_high_ff <= p_high;
      if (sample_start) begin
         acc_low_ff  <= '0;
         acc_mid_ff  <= '0;
         acc_high_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_low_ff  <= acc_low_ff + prod_low_ff;
         acc_mid_ff  <= acc_mid_ff + prod_mid_ff;
         acc_high_ff <= acc_high_ff + prod_high_ff;
      end
   end

   // The sums wrap at 31 bits, so scaling after the pass matches scaling
   // every product.
   always_ff @(posedge clock) begin
      if (ctl.load_gain) begin
         scl_low_ff  <= ACC_W'(acc_low_ff * ACC_W'(signed'(gain_low_ff)));
         scl_mid_ff  <= ACC_W'(acc_mid_ff * ACC_W'(signed'(gain_mid_ff)));
         scl_high_ff <= ACC_W'(acc_high_ff * ACC_W'(signed'(gain_high_ff)));
      end
   end

   assign total = scl_low_ff + scl_mid_ff + scl_high_ff;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= total[ACC_W-1:SHIFT_Q];
      end
   end

endmodule
